// ----- sv/frbr_pkg.sv -----
// Package for the framed byte ring buffer: request and result payload types,
// action and status codes, start byte values and the back-end state type.
// No dependencies.
package frbr_pkg;

    // Action codes of a request.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Status codes of a result.
    localparam logic [2:0] ST_ACCEPT  = 3'd0;
    localparam logic [2:0] ST_REJECT  = 3'd1;
    localparam logic [2:0] ST_FRAME   = 3'd2;
    localparam logic [2:0] ST_NOFRAME = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    // Bytes that open a frame.
    localparam logic [7:0] BYTE_DOLLAR = 8'h24;
    localparam logic [7:0] BYTE_AT     = 8'h40;

    // Configuration register indexes and reset value.
    localparam logic       REG_FRAME_LEN   = 1'b0;
    localparam logic [6:0] FRAME_LEN_RESET = 7'd16;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  data_byte;
        logic        chunk_first;
        logic [10:0] chunk_len;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_byte;
        logic        last;
        logic [10:0] fill_level;
        logic        not_empty;
    } t_res;

    // Queued request as seen by the back end.
    typedef struct packed {
        logic valid;
        t_req req;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SCAN,
        BS_FRAME
    } t_bstate;

endpackage

// ----- sv/frbr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module frbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/frbr_front.sv -----
// Front end of the framed byte ring buffer: takes requests, drops unused
// actions and holds the rest in a two-entry queue for the back end.
// Depends on frbr_pkg.
module frbr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  frbr_pkg::t_req i_req,
    output frbr_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import frbr_pkg::*;

    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign busy = (r_cnt == 2'd2);
    // A request with the unused action code is taken and leaves no trace.
    assign push = start && !busy && (i_req.action != ACT_NONE);
    assign pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_req;
        end
    end

    assign o_cmd.valid = (r_cnt != 2'd0);
    assign o_cmd.req   = r_q[r_rp];

endmodule

// ----- sv/frbr_back.sv -----
// Back end of the framed byte ring buffer: owns the ring pointers and the
// byte store, carries out writes, clears and frame reads, and drives results.
// Depends on frbr_pkg and frbr_ram.
module frbr_back #(
    parameter int BUF_DEPTH = 1024,
    parameter int MAX_FRAME = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  frbr_pkg::t_cmd i_cmd,
    output logic           o_pop,
    input  logic [6:0]     i_frame_len,
    output logic           o_res_valid,
    output frbr_pkg::t_res o_res
);
    import frbr_pkg::*;

    localparam int AW   = $clog2(BUF_DEPTH);
    localparam int CW   = $clog2(BUF_DEPTH + 1);
    localparam int CMPW = (CW > 11) ? CW : 11;

    t_bstate     r_state, n_state;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_count, n_count;
    logic        r_chunk_ok, n_chunk_ok;
    logic [6:0]  r_left, n_left;
    logic        r_pend, n_pend;
    logic        r_pend_last, n_pend_last;
    logic        r_res_vld;
    t_res        r_res;

    logic [6:0]    flen;
    logic [CMPW-1:0] flen_w;
    logic [CMPW-1:0] count_w;
    logic [CMPW-1:0] free_w;
    logic [CMPW-1:0] len_w;
    logic [CMPW-1:0] fill_w;
    logic [CW:0]   wsum;
    logic [AW-1:0] waddr;
    logic [AW-1:0] idx_inc;
    logic [7:0]    rdata;
    logic          is_start;
    logic          we;
    logic          ok;
    logic          emit;
    logic [CW-1:0] fill_src;
    logic [2:0]    e_status;
    logic [7:0]    e_byte;
    logic          e_last;

    // Out-of-range frame lengths are folded into the supported range.
    always_comb begin
        if (i_frame_len == 7'd0) begin
            flen = 7'd1;
        end else if (i_frame_len > 7'(MAX_FRAME)) begin
            flen = 7'(MAX_FRAME);
        end else begin
            flen = i_frame_len;
        end
    end

    assign flen_w   = CMPW'(flen);
    assign count_w  = CMPW'(r_count);
    assign free_w   = CMPW'(BUF_DEPTH) - count_w;
    assign len_w    = CMPW'(i_cmd.req.chunk_len);
    assign idx_inc  = (r_rd_idx == AW'(BUF_DEPTH - 1)) ? '0 : r_rd_idx + AW'(1);
    assign wsum     = (CW+1)'(r_rd_idx) + (CW+1)'(r_count);
    assign waddr    = (wsum >= (CW+1)'(BUF_DEPTH)) ? AW'(wsum - (CW+1)'(BUF_DEPTH))
                                                   : AW'(wsum);
    assign is_start = (rdata == BYTE_DOLLAR) || (rdata == BYTE_AT);

    // The read address is always the head: every pop reads there.
    frbr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.req.data_byte),
        .i_raddr (r_rd_idx),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_count     = r_count;
        n_chunk_ok  = r_chunk_ok;
        n_left      = r_left;
        n_pend      = 1'b0;
        n_pend_last = 1'b0;
        o_pop       = 1'b0;
        we          = 1'b0;
        ok          = 1'b0;
        emit        = 1'b0;
        e_status    = ST_REJECT;
        e_byte      = 8'd0;
        e_last      = 1'b1;
        fill_src    = r_count;

        // A frame byte read in the previous cycle leaves now.
        if (r_pend) begin
            emit     = 1'b1;
            e_status = ST_FRAME;
            e_byte   = rdata;
            e_last   = r_pend_last;
        end

        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd.valid && !r_pend) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.req.action)
                        ACT_WRITE: begin
                            if (i_cmd.req.chunk_first) begin
                                ok         = (len_w <= free_w);
                                n_chunk_ok = ok;
                            end else begin
                                ok = r_chunk_ok;
                            end
                            emit = 1'b1;
                            if (ok && (count_w < CMPW'(BUF_DEPTH))) begin
                                we       = 1'b1;
                                n_count  = r_count + CW'(1);
                                e_status = ST_ACCEPT;
                            end else begin
                                e_status = ST_REJECT;
                            end
                            fill_src = n_count;
                        end
                        ACT_READ: begin
                            if (count_w >= flen_w) begin
                                n_rd_idx = idx_inc;
                                n_count  = r_count - CW'(1);
                                n_state  = BS_SCAN;
                            end else begin
                                emit     = 1'b1;
                                e_status = ST_NOFRAME;
                            end
                        end
                        ACT_CLEAR: begin
                            n_rd_idx   = '0;
                            n_count    = '0;
                            n_chunk_ok = 1'b0;
                            emit       = 1'b1;
                            e_status   = ST_CLEARED;
                            fill_src   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BS_SCAN: begin
                // rdata holds the byte popped in the previous cycle.
                if (is_start) begin
                    // The rest of the frame is known to be there, so the
                    // count drops to its final value at once.
                    n_count  = CW'(count_w - (flen_w - CMPW'(1)));
                    emit     = 1'b1;
                    e_status = ST_FRAME;
                    e_byte   = rdata;
                    e_last   = (flen == 7'd1);
                    fill_src = n_count;
                    if (flen == 7'd1) begin
                        n_state = BS_IDLE;
                    end else begin
                        n_left  = flen - 7'd1;
                        n_state = BS_FRAME;
                    end
                end else if (count_w >= flen_w) begin
                    n_rd_idx = idx_inc;
                    n_count  = r_count - CW'(1);
                end else begin
                    emit     = 1'b1;
                    e_status = ST_NOFRAME;
                    n_state  = BS_IDLE;
                end
            end
            BS_FRAME: begin
                n_rd_idx    = idx_inc;
                n_left      = r_left - 7'd1;
                n_pend      = 1'b1;
                n_pend_last = (r_left == 7'd1);
                if (r_left == 7'd1) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    assign fill_w = CMPW'(fill_src);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_rd_idx    <= '0;
            r_count     <= '0;
            r_chunk_ok  <= 1'b0;
            r_left      <= 7'd0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_res_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_count     <= n_count;
            r_chunk_ok  <= n_chunk_ok;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_res_vld   <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res.status     <= e_status;
            r_res.out_byte   <= e_byte;
            r_res.last       <= e_last;
            r_res.fill_level <= fill_w[10:0];
            r_res.not_empty  <= (fill_src != '0);
        end
    end

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

endmodule

// ----- sv/framed_byte_ring_buffer.sv -----
// Top level of the framed byte ring buffer: configuration register port,
// front-end request queue and back-end ring engine.
// Depends on frbr_pkg, frbr_front, frbr_back and frbr_ram.
//
//  Channel    | Ports                                   | Handshake
//  -----------+-----------------------------------------+----------------------------
//  request    | start, busy, i_req                      | taken when start && !busy
//  result     | o_res_valid, o_res                      | one-cycle strobe, no stall
//  config     | psel, penable, pwrite, paddr, pwdata,   | APB write, pready always 1
//             | prdata, pready                          |
//
// A write or clear is handled by the back end in its idle state; with the queue empty its result
// is registered and on the ports in the cycle after the back end takes the request.
// A read pops and examines bytes one at a time until it finds a start byte, then reads the
// further frame bytes one at a time and sends each of them through a pending register; the
// single read port of the byte store sets this.
// Requests queue two deep; busy rises only when that queue is full.
// Reset is synchronous and empties the buffer; the byte store itself is not cleared.
module framed_byte_ring_buffer #(
    parameter int BUF_DEPTH = 1024,
    parameter int MAX_FRAME = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  frbr_pkg::t_req i_req,
    output logic           o_res_valid,
    output frbr_pkg::t_res o_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import frbr_pkg::*;

    logic [6:0] r_frame_len;
    t_cmd       cmd;
    logic       pop;
    logic       reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_FRAME_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_frame_len <= pwdata[6:0];
        end
    end

    assign prdata = (psel && reg_hit) ? {25'd0, r_frame_len} : 32'd0;

    frbr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_cmd   (cmd),
        .i_pop   (pop)
    );

    frbr_back #(
        .BUF_DEPTH (BUF_DEPTH),
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .i_frame_len (r_frame_len),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // Only frame bytes may leave a result open.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != ST_FRAME)) |-> o_res.last)
        else $error("non-frame result without last");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != ST_FRAME)) |-> (o_res.out_byte == 8'd0))
        else $error("byte field set on a non-frame result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy)
        else $error("busy straight after reset");

endmodule

// ----- tb/sv/tb_framed_byte_ring_buffer.sv -----
// Self-checking testbench for framed_byte_ring_buffer: drives write, read, clear and unused-action
// requests with random gaps and frame length writes, predicts every result and checks it field by field.
// Depends on frbr_pkg and framed_byte_ring_buffer.
module tb_framed_byte_ring_buffer;
    import frbr_pkg::*;

    localparam int         BUF_DEPTH      = 1024;
    localparam int         MAX_FRAME      = 64;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam logic [2:0] FRAME_LEN_ADDR = 3'(4 * int'(REG_FRAME_LEN));

    // Predicts the results of each accepted request and matches them against the block.
    class ring_buffer_checker;
        logic [7:0]  ring[BUF_DEPTH];
        logic [9:0]  head;
        logic [10:0] count;
        logic        chunk_ok;
        logic [6:0]  frame_len;
        t_res        due_results[$];
        int          errors;

        function new();
            head      = '0;
            count     = '0;
            chunk_ok  = 1'b0;
            frame_len = FRAME_LEN_RESET;
            errors    = 0;
        endfunction

        function int frame_size();
            if (frame_len == 7'd0) return 1;
            if (int'(frame_len) > MAX_FRAME) return MAX_FRAME;
            return int'(frame_len);
        endfunction

        // The fill level is that after the whole request, so results are queued last.
        function void queue_result(logic [2:0] st, logic [7:0] b, logic lst);
            t_res e;
            e.status     = st;
            e.out_byte   = b;
            e.last       = lst;
            e.fill_level = count;
            e.not_empty  = (count != 11'd0);
            due_results.push_back(e);
        endfunction

        function logic [7:0] pop_byte();
            logic [7:0] b;
            b     = ring[head];
            head  = head + 10'd1;
            count = count - 11'd1;
            return b;
        endfunction

        function void take_request(t_req r);
            logic [7:0] frame[MAX_FRAME];
            logic [7:0] b;
            int         flen;
            case (r.action)
                ACT_WRITE: begin
                    if (r.chunk_first)
                        chunk_ok = (int'(r.chunk_len) <= BUF_DEPTH - int'(count));
                    if (chunk_ok && int'(count) < BUF_DEPTH) begin
                        ring[10'(head + count[9:0])] = r.data_byte;
                        count = count + 11'd1;
                        queue_result(ST_ACCEPT, 8'h00, 1'b1);
                    end else begin
                        queue_result(ST_REJECT, 8'h00, 1'b1);
                    end
                end
                ACT_READ: begin
                    flen = frame_size();
                    while (int'(count) >= flen) begin
                        b = pop_byte();
                        if (b == BYTE_DOLLAR || b == BYTE_AT) begin
                            frame[0] = b;
                            for (int i = 1; i < flen; i++) frame[i] = pop_byte();
                            for (int i = 0; i < flen; i++)
                                queue_result(ST_FRAME, frame[i], i == flen - 1);
                            return;
                        end
                    end
                    queue_result(ST_NOFRAME, 8'h00, 1'b1);
                end
                ACT_CLEAR: begin
                    head     = '0;
                    count    = '0;
                    chunk_ok = 1'b0;
                    queue_result(ST_CLEARED, 8'h00, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (due_results.size() == 0) begin
                $error("unexpected result: status %0d, byte %02h", got.status, got.out_byte);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte mismatch: expected %02h, got %02h", want.out_byte,
                       got.out_byte);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last mismatch: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
            if (got.fill_level !== want.fill_level) begin
                $error("fill_level mismatch: expected %0d, got %0d", want.fill_level,
                       got.fill_level);
                errors++;
            end
            if (got.not_empty !== want.not_empty) begin
                $error("not_empty mismatch: expected %0b, got %0b", want.not_empty,
                       got.not_empty);
                errors++;
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_res_valid;
    t_res        o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ring_buffer_checker ring_sb;
    int                 quiet_cycles = 0;
    bit                 no_gaps      = 1'b0;

    framed_byte_ring_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_res_valid) begin
                ring_sb.check_result(o_res);
                quiet_cycles = 0;
            end
            if (start && !busy) begin
                ring_sb.take_request(i_req);
                quiet_cycles = 0;
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("FAIL framed_byte_ring_buffer");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        if (no_gaps) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A request of the given action with every other field random.
    function automatic t_req any_req(logic [1:0] act);
        logic [31:0] w;
        t_req        r;
        w        = $urandom;
        r        = w[$bits(t_req)-1:0];
        r.action = act;
        return r;
    endfunction

    // Appends well-formed frames, each behind up to three bytes that cannot start a frame.
    function automatic void make_burst(int flen, int frames, ref logic [7:0] bytes[$]);
        logic [7:0] b;
        repeat (frames) begin
            repeat ($urandom_range(0, 3)) begin
                do b = 8'($urandom); while (b == BYTE_DOLLAR || b == BYTE_AT);
                bytes.push_back(b);
            end
            bytes.push_back($urandom_range(0, 1) ? BYTE_DOLLAR : BYTE_AT);
            repeat (flen - 1) bytes.push_back(8'($urandom));
        end
    endfunction

    task automatic send(t_req r);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic put_chunk(input logic [7:0] bytes[$], input logic [10:0] announced);
        t_req r;
        foreach (bytes[i]) begin
            r             = any_req(ACT_WRITE);
            r.data_byte   = bytes[i];
            r.chunk_first = (i == 0);
            if (i == 0) r.chunk_len = announced;
            send(r);
        end
    endtask

    // An ignored request leaves nothing to wait for, hence the settling cycles.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (ring_sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_len(logic [6:0] value);
        wait_drained();
        @(negedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= FRAME_LEN_ADDR;
        pwdata <= {25'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ring_sb.frame_len = value;
    endtask

    task automatic run_directed();
        logic [7:0] bytes[$];
        t_req       r;
        // Bytes without a chunk start after reset are refused.
        r = '0;
        r.data_byte = 8'hFF;
        send(r);
        send(any_req(ACT_READ));
        r = '1;
        send(r);
        // A zero-length chunk always fits; the longest announced length never does.
        r = '0;
        r.chunk_first = 1'b1;
        send(r);
        r = '1;
        r.action = ACT_WRITE;
        send(r);
        r = '0;
        r.data_byte = 8'hAA;
        send(r);
        send(any_req(ACT_CLEAR));

        write_frame_len(7'd1);
        bytes = '{BYTE_DOLLAR, 8'h55, BYTE_AT, 8'h00};
        put_chunk(bytes, 11'd4);
        repeat (3) send(any_req(ACT_READ));

        // Zero is taken as one, anything above the largest frame as the largest.
        write_frame_len(7'd0);
        bytes = '{BYTE_AT};
        put_chunk(bytes, 11'd1);
        send(any_req(ACT_READ));
        write_frame_len(7'd127);
        bytes = '{BYTE_DOLLAR, 8'h7F};
        put_chunk(bytes, 11'd2);
        send(any_req(ACT_READ));

        write_frame_len(7'd3);
        bytes = '{8'h80, BYTE_DOLLAR, 8'h01, 8'h02, BYTE_AT};
        put_chunk(bytes, 11'd5);
        repeat (3) send(any_req(ACT_READ));
    endtask

    task automatic run_random(logic [6:0] fl, int budget);
        logic [7:0] bytes[$];
        t_req       r;
        int         done;
        int         pick;
        int         flen;
        int         n;
        write_frame_len(fl);
        flen = ring_sb.frame_size();
        done = 0;
        while (done < budget) begin
            if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                bytes.delete();
                make_burst(flen, (flen > 16) ? 1 : $urandom_range(1, 3), bytes);
                // Some chunks stop short of a whole frame.
                if (bytes.size() > 1 && $urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, bytes.size() - 1)) void'(bytes.pop_back());
                n = bytes.size();
                put_chunk(bytes, ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                                              : 11'(n));
                done += n;
            end else if (pick < 75) begin
                send(any_req(ACT_READ));
                done++;
            end else if (pick < 79) begin
                send(any_req(ACT_CLEAR));
                done++;
            end else if (pick < 83) begin
                send(any_req(ACT_NONE));
            end else if (pick < 95) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    r = any_req(ACT_WRITE);
                    r.chunk_first = ($urandom_range(0, 3) == 0);
                    send(r);
                end
                done += n;
            end else if (pick < 97) begin
                wait_drained();
            end else begin
                repeat (3) send(any_req(ACT_READ));
                done += 3;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        ring_sb  = new();
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_req    = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(7'd64, 90);
        run_random(7'd1, 45);
        run_random(7'd2, 45);
        run_random(7'($urandom_range(3, 63)), 50);
        run_random(7'($urandom_range(0, 127)), 50);

        wait_drained();
        if (ring_sb.errors == 0)
            $display("PASS framed_byte_ring_buffer");
        else
            $display("FAIL framed_byte_ring_buffer");
        $finish;
    end
endmodule
